/* design/trilinear_grid_weights_unit_defines.svh */
// Assertion macros shared by the checker of the trilinear grid weights unit.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef TRILINEAR_GRID_WEIGHTS_UNIT_DEFINES_SVH
`define TRILINEAR_GRID_WEIGHTS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TGW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TGW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tgw_pkg.sv */
// Package of the trilinear grid weights unit: widths, register indexes and
// the payload and control structs. Depends on nothing.
package tgw_pkg;

    // Design constants.
    localparam int MAX_GRID_DIM     = 1024;
    localparam int WEIGHT_FRAC_BITS = 16;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 32;
    localparam int ID_W     = 20;
    localparam int NODE_W   = 30;
    localparam int CORNER_W = 3;
    localparam int DIM_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 2 * COORD_W;

    // Widths derived from the design constants.
    localparam int FRAC_W   = WEIGHT_FRAC_BITS;
    localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;
    localparam int LIM_W    = $clog2(MAX_GRID_DIM + 1);
    localparam int CELL_W   = (MAX_GRID_DIM > 2) ? $clog2(MAX_GRID_DIM) : 1;
    localparam int SPAN_W   = CELL_W + LIM_W + 1;
    localparam int AREA_W   = 2 * LIM_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1) << FRAC_W;
    localparam logic [CORNER_W-1:0] LAST_CORNER = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH    = 3'd0,
        REG_GRID_HEIGHT   = 3'd1,
        REG_GRID_DEPTH    = 3'd2,
        REG_INV_CELL_SIZE = 3'd3,
        REG_ORIGIN_X      = 3'd4,
        REG_ORIGIN_Y      = 3'd5,
        REG_ORIGIN_Z      = 3'd6
    } tgw_reg_t;

    // Input transaction payload.
    typedef struct packed {
        logic [ID_W-1:0]           point_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } tgw_point_t;

    // Output transaction payload.
    typedef struct packed {
        logic [ID_W-1:0]     row_id;
        logic [NODE_W-1:0]   node_index;
        logic [CORNER_W-1:0] corner_code;
        logic [WEIGHT_W-1:0] weight;
        logic                out_of_range;
        logic                last;
    } tgw_result_t;

    // Configuration as seen by the datapath; grid sizes already clamped.
    typedef struct packed {
        logic [LIM_W-1:0]          nx;
        logic [LIM_W-1:0]          ny;
        logic [LIM_W-1:0]          nz;
        logic [COORD_W-1:0]        inv;
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic signed [COORD_W-1:0] org_z;
    } tgw_cfg_t;

    // Load enables of the front-end stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } tgw_stage_en_t;

    // Per-point record handed from the front end to the corner sequencer.
    typedef struct packed {
        logic [ID_W-1:0]               row_id;
        logic [NODE_W-1:0]             base;
        logic [NODE_W-1:0]             nxny;
        logic [3:0][WEIGHT_W-1:0]      wxy;
        logic [FRAC_W-1:0]             fz;
        logic                          oor;
    } tgw_rec_t;

    // Clamp a grid size to the largest supported dimension.
    function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
        if (32'(raw) > 32'(MAX_GRID_DIM)) begin
            return LIM_W'(MAX_GRID_DIM);
        end
        return LIM_W'(raw);
    endfunction

endpackage

/* design/trilinear_grid_weights_unit.sv */
// Trilinear grid weights unit: eight corner node indexes and weights per point.
// Each point passes the front-end pipeline, the hold register of the corner
// sequencer and the output register; its eight corners leave one after another
// through the single corner result port, while later points may queue in the front end.
// Reset: rst_n clears all valid bits and loads the register reset values.
module trilinear_grid_weights_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           point_valid,
    output logic                           point_ready,
    input  tgw_pkg::tgw_point_t            point,
    output logic                           result_valid,
    input  logic                           result_ready,
    output tgw_pkg::tgw_result_t           result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tgw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgw_pkg::COORD_W-1:0]    cfg_data
);

    tgw_pkg::tgw_cfg_t cfg;
    tgw_pkg::tgw_rec_t rec;
    logic              rec_valid;
    logic              rec_ready;

    // Configuration registers.
    tgw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Per-point pipeline.
    tgw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .cfg         (cfg),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    // Corner sequencer and output register.
    tgw_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .rec          (rec),
        .nx           (cfg.nx),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* design/tgw_cfg.sv */
// Configuration register file of the trilinear grid weights unit.
// Depends on tgw_pkg.
module tgw_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tgw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgw_pkg::COORD_W-1:0]      cfg_data,
    output tgw_pkg::tgw_cfg_t                cfg
);

    tgw_pkg::tgw_cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; grid sizes are clamped as they are stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx    <= tgw_pkg::LIM_W'(2);
            cfg_reg.ny    <= tgw_pkg::LIM_W'(2);
            cfg_reg.nz    <= tgw_pkg::LIM_W'(2);
            cfg_reg.inv   <= tgw_pkg::COORD_W'(65536);
            cfg_reg.org_x <= '0;
            cfg_reg.org_y <= '0;
            cfg_reg.org_z <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tgw_pkg::REG_GRID_WIDTH:
                    cfg_reg.nx <= tgw_pkg::clamp_dim(cfg_data[tgw_pkg::DIM_W-1:0]);
                tgw_pkg::REG_GRID_HEIGHT:
                    cfg_reg.ny <= tgw_pkg::clamp_dim(cfg_data[tgw_pkg::DIM_W-1:0]);
                tgw_pkg::REG_GRID_DEPTH:
                    cfg_reg.nz <= tgw_pkg::clamp_dim(cfg_data[tgw_pkg::DIM_W-1:0]);
                tgw_pkg::REG_INV_CELL_SIZE: cfg_reg.inv   <= cfg_data;
                tgw_pkg::REG_ORIGIN_X:      cfg_reg.org_x <= cfg_data;
                tgw_pkg::REG_ORIGIN_Y:      cfg_reg.org_y <= cfg_data;
                tgw_pkg::REG_ORIGIN_Z:      cfg_reg.org_z <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* design/tgw_axis.sv */
// One coordinate axis: offset, scaling by the reciprocal cell size, floor,
// fraction and range check over three register stages. Depends on tgw_pkg.
module tgw_axis (
    input  logic                              clk,
    input  tgw_pkg::tgw_stage_en_t            en,
    input  logic signed [tgw_pkg::COORD_W-1:0] pos,
    input  logic signed [tgw_pkg::COORD_W-1:0] org,
    input  logic [tgw_pkg::COORD_W-1:0]       inv,
    input  logic [tgw_pkg::LIM_W-1:0]         dim,
    output logic [tgw_pkg::CELL_W-1:0]        cell_idx,
    output logic [tgw_pkg::FRAC_W-1:0]        frac,
    output logic                              ok
);

    logic signed [tgw_pkg::COORD_W:0]  diff;
    logic                              neg;
    logic [tgw_pkg::COORD_W-1:0]       mag;
    logic                              neg1_reg;
    logic [tgw_pkg::COORD_W-1:0]       mag1_reg;
    logic [tgw_pkg::PROD_W-1:0]        prod;
    logic                              neg2_reg;
    logic [tgw_pkg::PROD_W-1:0]        prod2_reg;
    logic [tgw_pkg::COORD_W-1:0]       hi;
    logic [tgw_pkg::COORD_W-1:0]       lo;
    logic [tgw_pkg::COORD_W-1:0]       fr_full;
    logic [tgw_pkg::COORD_W:0]         hi_plus;
    logic                              ok_next;
    logic [tgw_pkg::CELL_W-1:0]        cell_next;
    logic [tgw_pkg::CELL_W-1:0]        cell_reg;
    logic [tgw_pkg::FRAC_W-1:0]        frac_reg;
    logic                              ok_reg;

    // Stage 1: exact offset from the grid corner as sign and magnitude.
    assign diff = {pos[tgw_pkg::COORD_W-1], pos} - {org[tgw_pkg::COORD_W-1], org};
    assign neg  = diff[tgw_pkg::COORD_W];
    assign mag  = neg ? tgw_pkg::COORD_W'(-diff) : diff[tgw_pkg::COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg <= neg;
            mag1_reg <= mag;
        end
    end

    // Stage 2: magnitude times reciprocal cell size, Q32.32.
    assign prod = mag1_reg * inv;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod;
        end
    end

    // Stage 3: floor and fraction. A negative coordinate with a nonzero
    // fraction floors one below its negated integer part, so only the exact
    // zero product can land in cell zero from the negative side.
    assign hi      = prod2_reg[tgw_pkg::PROD_W-1:tgw_pkg::COORD_W];
    assign lo      = prod2_reg[tgw_pkg::COORD_W-1:0];
    assign fr_full = neg2_reg ? (tgw_pkg::COORD_W'(0) - lo) : lo;
    assign hi_plus = {1'b0, hi} + (tgw_pkg::COORD_W + 1)'(2);
    assign ok_next = (!neg2_reg || (hi == '0 && lo == '0))
                  && (hi_plus <= (tgw_pkg::COORD_W + 1)'(dim));
    assign cell_next = neg2_reg ? '0 : hi[tgw_pkg::CELL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            cell_reg <= cell_next;
            frac_reg <= fr_full[tgw_pkg::COORD_W-1 -: tgw_pkg::FRAC_W];
            ok_reg   <= ok_next;
        end
    end

    assign cell_idx = cell_reg;
    assign frac     = frac_reg;
    assign ok       = ok_reg;

endmodule

/* design/tgw_front.sv */
// Front-end pipeline: five stages from a point to its cell base index and
// the four x-y weight products. Depends on tgw_pkg and tgw_axis.
module tgw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_ready,
    input  tgw_pkg::tgw_point_t   point,
    input  tgw_pkg::tgw_cfg_t     cfg,
    output logic                  rec_valid,
    input  logic                  rec_ready,
    output tgw_pkg::tgw_rec_t     rec
);

    tgw_pkg::tgw_stage_en_t en;
    logic [5:1] v_reg;

    logic [tgw_pkg::ID_W-1:0]   id1_reg;
    logic [tgw_pkg::ID_W-1:0]   id2_reg;
    logic [tgw_pkg::ID_W-1:0]   id3_reg;

    logic [tgw_pkg::CELL_W-1:0] ci;
    logic [tgw_pkg::CELL_W-1:0] cj;
    logic [tgw_pkg::CELL_W-1:0] ck;
    logic [tgw_pkg::FRAC_W-1:0] fx;
    logic [tgw_pkg::FRAC_W-1:0] fy;
    logic [tgw_pkg::FRAC_W-1:0] fz;
    logic                       okx;
    logic                       oky;
    logic                       okz;

    logic [tgw_pkg::SPAN_W-1:0]          span_next;
    logic [tgw_pkg::AREA_W-1:0]          area_next;
    logic [3:0][tgw_pkg::WEIGHT_W-1:0]   wxy_next;
    logic [tgw_pkg::WEIGHT_W-1:0]        wx;
    logic [tgw_pkg::WEIGHT_W-1:0]        wy;
    logic [2*tgw_pkg::WEIGHT_W-1:0]      pxy;

    logic [tgw_pkg::ID_W-1:0]            id4_reg;
    logic [tgw_pkg::CELL_W-1:0]          i4_reg;
    logic [tgw_pkg::SPAN_W-1:0]          span4_reg;
    logic [tgw_pkg::AREA_W-1:0]          area4_reg;
    logic [3:0][tgw_pkg::WEIGHT_W-1:0]   wxy4_reg;
    logic [tgw_pkg::FRAC_W-1:0]          fz4_reg;
    logic                                oor4_reg;

    logic [tgw_pkg::LIM_W+tgw_pkg::SPAN_W:0] base_full;
    tgw_pkg::tgw_rec_t                        rec_next;
    tgw_pkg::tgw_rec_t                        rec5_reg;

    // Stall chain: a stage loads when it is empty or its successor loads.
    assign en.s5 = !v_reg[5] || rec_ready;
    assign en.s4 = !v_reg[4] || en.s5;
    assign en.s3 = !v_reg[3] || en.s4;
    assign en.s2 = !v_reg[2] || en.s3;
    assign en.s1 = !v_reg[1] || en.s2;
    assign point_ready = en.s1;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en.s1) v_reg[1] <= point_valid;
            if (en.s2) v_reg[2] <= v_reg[1];
            if (en.s3) v_reg[3] <= v_reg[2];
            if (en.s4) v_reg[4] <= v_reg[3];
            if (en.s5) v_reg[5] <= v_reg[4];
        end
    end

    // Point identifier through the first three stages.
    always_ff @(posedge clk)
    begin
        if (en.s1) id1_reg <= point.point_id;
        if (en.s2) id2_reg <= id1_reg;
        if (en.s3) id3_reg <= id2_reg;
    end

    // Stages 1 to 3 for each axis.
    tgw_axis u_axis_x (
        .clk      (clk),
        .en       (en),
        .pos      (point.pos_x),
        .org      (cfg.org_x),
        .inv      (cfg.inv),
        .dim      (cfg.nx),
        .cell_idx (ci),
        .frac     (fx),
        .ok       (okx)
    );

    tgw_axis u_axis_y (
        .clk      (clk),
        .en       (en),
        .pos      (point.pos_y),
        .org      (cfg.org_y),
        .inv      (cfg.inv),
        .dim      (cfg.ny),
        .cell_idx (cj),
        .frac     (fy),
        .ok       (oky)
    );

    tgw_axis u_axis_z (
        .clk      (clk),
        .en       (en),
        .pos      (point.pos_z),
        .org      (cfg.org_z),
        .inv      (cfg.inv),
        .dim      (cfg.nz),
        .cell_idx (ck),
        .frac     (fz),
        .ok       (okz)
    );

    // Stage 4: j + k*ny, the layer size nx*ny and the four x-y products.
    // Product index bit 0 selects the x+1 corner, bit 1 the y+1 corner.
    assign span_next = tgw_pkg::SPAN_W'(cj)
                     + tgw_pkg::SPAN_W'(ck) * tgw_pkg::SPAN_W'(cfg.ny);
    assign area_next = tgw_pkg::AREA_W'(cfg.nx) * tgw_pkg::AREA_W'(cfg.ny);

    always_comb
    begin
        wx  = '0;
        wy  = '0;
        pxy = '0;
        for (int c = 0; c < 4; c++)
        begin
            wx  = c[0] ? tgw_pkg::WEIGHT_W'(fx) : tgw_pkg::WEIGHT_ONE - tgw_pkg::WEIGHT_W'(fx);
            wy  = c[1] ? tgw_pkg::WEIGHT_W'(fy) : tgw_pkg::WEIGHT_ONE - tgw_pkg::WEIGHT_W'(fy);
            pxy = wx * wy;
            wxy_next[c] = pxy[tgw_pkg::FRAC_W +: tgw_pkg::WEIGHT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            id4_reg   <= id3_reg;
            i4_reg    <= ci;
            span4_reg <= span_next;
            area4_reg <= area_next;
            wxy4_reg  <= wxy_next;
            fz4_reg   <= fz;
            oor4_reg  <= !(okx && oky && okz);
        end
    end

    // Stage 5: base node index i + nx*(j + k*ny); zero outside the grid.
    assign base_full = (tgw_pkg::LIM_W + tgw_pkg::SPAN_W + 1)'(cfg.nx)
                     * (tgw_pkg::LIM_W + tgw_pkg::SPAN_W + 1)'(span4_reg)
                     + (tgw_pkg::LIM_W + tgw_pkg::SPAN_W + 1)'(i4_reg);

    always_comb
    begin
        rec_next.row_id = id4_reg;
        rec_next.base   = oor4_reg ? '0 : tgw_pkg::NODE_W'(base_full);
        rec_next.nxny   = tgw_pkg::NODE_W'(area4_reg);
        rec_next.wxy    = wxy4_reg;
        rec_next.fz     = fz4_reg;
        rec_next.oor    = oor4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            rec5_reg <= rec_next;
        end
    end

    assign rec_valid = v_reg[5];
    assign rec       = rec5_reg;

endmodule

/* design/tgw_emit.sv */
// Corner sequencer: holds one point record and sends its eight corner
// results, one per cycle while the output is not stalled, through an output register. Depends on tgw_pkg.
module tgw_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rec_valid,
    output logic                        rec_ready,
    input  tgw_pkg::tgw_rec_t           rec,
    input  logic [tgw_pkg::LIM_W-1:0]   nx,
    output logic                        result_valid,
    input  logic                        result_ready,
    output tgw_pkg::tgw_result_t        result
);

    tgw_pkg::tgw_rec_t                 hold_reg;
    logic                              hold_valid_reg;
    logic [tgw_pkg::CORNER_W-1:0]      corner_reg;
    tgw_pkg::tgw_result_t              result_reg;
    tgw_pkg::tgw_result_t              result_next;
    logic                              result_valid_reg;

    logic                              out_load;
    logic                              emit;
    logic [tgw_pkg::WEIGHT_W-1:0]      wz;
    logic [tgw_pkg::WEIGHT_W-1:0]      wxy;
    logic [2*tgw_pkg::WEIGHT_W-1:0]    wprod;
    logic [tgw_pkg::NODE_W-1:0]        node;

    // A corner leaves whenever the output register is free or being drained.
    assign out_load  = !result_valid_reg || result_ready;
    assign emit      = hold_valid_reg && out_load;
    assign rec_ready = !hold_valid_reg || (emit && corner_reg == tgw_pkg::LAST_CORNER);

    // Weight and node index of the current corner.
    assign wz    = corner_reg[2] ? tgw_pkg::WEIGHT_W'(hold_reg.fz)
                                 : tgw_pkg::WEIGHT_ONE - tgw_pkg::WEIGHT_W'(hold_reg.fz);
    assign wxy   = hold_reg.wxy[corner_reg[1:0]];
    assign wprod = wxy * wz;
    assign node  = hold_reg.base
                 + (corner_reg[0] ? tgw_pkg::NODE_W'(1) : '0)
                 + (corner_reg[1] ? tgw_pkg::NODE_W'(nx) : '0)
                 + (corner_reg[2] ? hold_reg.nxny : '0);

    always_comb
    begin
        result_next.row_id       = hold_reg.row_id;
        result_next.node_index   = hold_reg.oor ? '0 : node;
        result_next.corner_code  = corner_reg;
        result_next.weight       = wprod[tgw_pkg::FRAC_W +: tgw_pkg::WEIGHT_W];
        result_next.out_of_range = hold_reg.oor;
        result_next.last         = (corner_reg == tgw_pkg::LAST_CORNER);
    end

    // Hold register and corner counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            corner_reg     <= '0;
        end
        else
        begin
            if (rec_ready)
            begin
                hold_valid_reg <= rec_valid;
            end
            if (emit)
            begin
                corner_reg <= corner_reg + tgw_pkg::CORNER_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_ready && rec_valid)
        begin
            hold_reg <= rec;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* design/tgw_checker.sv */
// Port-level checker of the trilinear grid weights unit, bound to the top.
// Depends on tgw_pkg and trilinear_grid_weights_unit_defines.svh.
`include "trilinear_grid_weights_unit_defines.svh"

module tgw_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  tgw_pkg::tgw_result_t  result
);

    // A stalled result transaction keeps its payload.
    `TGW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

    // Corners of one point follow each other without gaps, in order.
    `TGW_ASSERT_NEXT(a_corner_seq, result_valid && result_ready && !result.last, result_valid && result.corner_code == $past(result.corner_code) + 3'd1 && result.row_id == $past(result.row_id), "corner sequence broken")

    // The last mark sits on the final corner only.
    `TGW_ASSERT_NOW(a_last_corner, result_valid, result.last == (result.corner_code == tgw_pkg::LAST_CORNER), "last mark on wrong corner")

    // Cells outside the grid report node zero.
    `TGW_ASSERT_NOW(a_oor_node, result_valid && result.out_of_range, result.node_index == '0, "nonzero node index outside grid")

endmodule

bind trilinear_grid_weights_unit tgw_checker u_tgw_checker (.*);
